FILE: src/assert_macros.svh
// Assertion macros used by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

FILE: src/sopc_pkg.sv
// Types, codes and constants of the safety output port controller.
package sopc_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MASK_W        = 8;
  localparam int FAULT_IDX_W   = 3;
  localparam int LINE_W        = 6;
  localparam int SEC_W         = 16;
  localparam int TIME_W        = 32;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ADD   = 2'd2,
    OP_SAFE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_REFUSED = 3'd2,
    ST_FAILED  = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    SEQ_IDLE = 4'b0001,
    SEQ_WDOG = 4'b0010,
    SEQ_SCAN = 4'b0100,
    SEQ_DONE = 4'b1000
  } seq_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TIME_W-1:0] now;
    logic [LINE_W-1:0] line_number;
    logic              level_request;
    logic              line_active_high;
    logic [SEC_W-1:0]  max_on_seconds;
    logic [MASK_W-1:0] drive_fault_mask;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              line_level;
    logic              tripped;
    logic              link_timeout;
    logic [MASK_W-1:0] line_levels;
    logic [MASK_W-1:0] release_failed_mask;
  } out_item_t;

endpackage

FILE: src/safety_output_port_controller.sv
// Safety output port controller: slot table, level writes, ticks and watchdog.
//
// Usage: pulse start with a command word on cmd while busy is low; the word is
// taken at that edge and busy stays high until the result has been shown.
// The result word appears on result for exactly one cycle with done high; the
// receiver cannot stall it and must take it in that cycle.
// Write the watchdog limit via cfg_we / cfg_wdata only while idle; the block does not check it.
//
// One small sequencer walks the slot table one slot per cycle. Steps per command:
//   tick:        watchdog check, slot walk, result
//   force safe:  slot walk, result
//   write:       search to the matching slot (whole table if unknown), result
//   add:         duplicate search, then the new slot, result; no search when
//                the table is full
// A new command is taken the cycle after done.
// Reset (rst, synchronous) empties the table, clears the trip and watchdog
// latches, disarms the watchdog and sets the limit to zero.
module safety_output_port_controller
  import sopc_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         cmd,
  input  logic             cfg_we,
  input  logic [SEC_W-1:0] cfg_wdata,
  output logic             done,
  output out_item_t        result
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

  seq_t              state;
  in_item_t          item;
  logic [CNT_W-1:0]  idx;
  logic              fire;
  status_t           status;
  logic              line_level;

  logic [SEC_W-1:0]  watchdog_seconds;
  logic [TIME_W-1:0] last_write_time;
  logic              watchdog_latch;
  logic              trip_latch;
  logic [CNT_W-1:0]  slot_count;

  logic [LINE_W-1:0] slot_line           [NUM_SLOTS];
  logic              slot_polarity       [NUM_SLOTS];
  logic [SEC_W-1:0]  slot_max_on         [NUM_SLOTS];
  logic              slot_active         [NUM_SLOTS];
  logic [TIME_W:0]   slot_deadline       [NUM_SLOTS];
  logic              slot_release_failed [NUM_SLOTS];

  logic [SLOT_W-1:0] idx_s;
  logic              in_range;
  logic              fault;
  logic              due;
  logic              full;
  logic              line_hit;
  logic              add_commit;
  logic              accept;
  logic              fire_next;
  logic signed [TIME_W+1:0] silence;
  logic [MASK_W-1:0] levels;
  logic [MASK_W-1:0] relmask;

  assign accept = start && (state == SEQ_IDLE);
  assign busy   = (state != SEQ_IDLE);
  assign done   = (state == SEQ_DONE);

  always_comb begin
    idx_s    = idx[SLOT_W-1:0];
    in_range = (idx < slot_count);
    fault    = item.drive_fault_mask[FAULT_IDX_W'(idx_s)];
    due      = slot_active[idx_s] && (slot_deadline[idx_s] != '0) &&
               ({1'b0, item.now} >= slot_deadline[idx_s]);
    full     = (slot_count >= CNT_W'(NUM_SLOTS));
    line_hit = (slot_line[idx_s] == item.line_number);
    add_commit = (state == SEQ_SCAN) && (op_t'(item.operation) == OP_ADD) &&
                 !full && !in_range && !fault;
  end

  // Signed silence since the last write, compared against the limit.
  always_comb begin
    silence   = $signed({2'b00, item.now}) - $signed({2'b00, last_write_time});
    fire_next = (watchdog_seconds != '0) && (last_write_time != '0) && !watchdog_latch &&
                (silence > $signed({{(TIME_W + 2 - SEC_W){1'b0}}, watchdog_seconds}));
  end

  // Slot payload: written only when an add commits.
  always_ff @(posedge clk) begin
    if (add_commit) begin
      slot_line[idx_s]     <= item.line_number;
      slot_polarity[idx_s] <= item.line_active_high;
      slot_max_on[idx_s]   <= item.max_on_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= SEQ_IDLE;
      idx              <= '0;
      fire             <= 1'b0;
      status           <= ST_OK;
      line_level       <= 1'b0;
      watchdog_seconds <= '0;
      last_write_time  <= '0;
      watchdog_latch   <= 1'b0;
      trip_latch       <= 1'b0;
      slot_count       <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_active[i]         <= 1'b0;
        slot_deadline[i]       <= '0;
        slot_release_failed[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        watchdog_seconds <= cfg_wdata;
      end
      case (state)
        SEQ_IDLE: begin
          if (accept) begin
            item       <= cmd;
            idx        <= '0;
            fire       <= 1'b0;
            status     <= ST_OK;
            line_level <= 1'b0;
            if (op_t'(cmd.operation) == OP_WRITE) begin
              last_write_time <= cmd.now;
              watchdog_latch  <= 1'b0;
            end
            state <= (op_t'(cmd.operation) == OP_TICK) ? SEQ_WDOG : SEQ_SCAN;
          end
        end
        SEQ_WDOG: begin
          fire <= fire_next;
          if (fire_next) begin
            watchdog_latch <= 1'b1;
          end
          state <= SEQ_SCAN;
        end
        SEQ_SCAN: begin
          case (op_t'(item.operation))
            OP_TICK, OP_SAFE: begin
              if (in_range) begin
                if (fire || (op_t'(item.operation) == OP_SAFE)) begin
                  if (fault) begin
                    slot_release_failed[idx_s] <= 1'b1;
                    trip_latch                 <= 1'b1;
                    status                     <= ST_FAILED;
                  end else begin
                    slot_active[idx_s]         <= 1'b0;
                    slot_deadline[idx_s]       <= '0;
                    slot_release_failed[idx_s] <= 1'b0;
                  end
                end else if (due) begin
                  if (fault) begin
                    slot_release_failed[idx_s] <= 1'b1;
                    trip_latch                 <= 1'b1;
                    status                     <= ST_FAILED;
                  end else begin
                    slot_active[idx_s]   <= 1'b0;
                    slot_deadline[idx_s] <= '0;
                  end
                end
                idx <= idx + CNT_W'(1);
              end else begin
                state <= SEQ_DONE;
              end
            end
            OP_WRITE: begin
              if (in_range) begin
                if (line_hit) begin
                  if (item.level_request && trip_latch) begin
                    status     <= ST_REFUSED;
                    line_level <= slot_active[idx_s];
                  end else if (fault) begin
                    status     <= ST_FAILED;
                    line_level <= slot_active[idx_s];
                    if (!item.level_request) begin
                      slot_release_failed[idx_s] <= 1'b1;
                      trip_latch                 <= 1'b1;
                    end
                  end else begin
                    slot_active[idx_s]         <= item.level_request;
                    slot_release_failed[idx_s] <= 1'b0;
                    line_level                 <= item.level_request;
                    if (item.level_request && (slot_max_on[idx_s] != '0)) begin
                      slot_deadline[idx_s] <= {1'b0, item.now} +
                                              {{(TIME_W + 1 - SEC_W){1'b0}}, slot_max_on[idx_s]};
                    end else begin
                      slot_deadline[idx_s] <= '0;
                    end
                  end
                  state <= SEQ_DONE;
                end else begin
                  idx <= idx + CNT_W'(1);
                end
              end else begin
                status <= ST_UNKNOWN;
                state  <= SEQ_DONE;
              end
            end
            OP_ADD: begin
              if (full) begin
                status <= ST_FULL;
                state  <= SEQ_DONE;
              end else if (in_range) begin
                if (line_hit) begin
                  status <= ST_FULL;
                  state  <= SEQ_DONE;
                end else begin
                  idx <= idx + CNT_W'(1);
                end
              end else begin
                // Search reached the first free slot: bring it up released, or fail on a fault.
                if (fault) begin
                  status <= ST_FAILED;
                end else begin
                  slot_active[idx_s]         <= 1'b0;
                  slot_deadline[idx_s]       <= '0;
                  slot_release_failed[idx_s] <= 1'b0;
                  slot_count                 <= slot_count + CNT_W'(1);
                end
                state <= SEQ_DONE;
              end
            end
            default: begin
              state <= SEQ_DONE;
            end
          endcase
        end
        SEQ_DONE: begin
          state <= SEQ_IDLE;
        end
        default: begin
          state <= SEQ_IDLE;
        end
      endcase
    end
  end

  // Map each slot in use through its polarity.
  always_comb begin
    levels  = '0;
    relmask = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (CNT_W'(i) < slot_count) begin
        levels[i]  = slot_active[i] ? slot_polarity[i] : !slot_polarity[i];
        relmask[i] = slot_release_failed[i];
      end
    end
  end

  always_comb begin
    result.status              = status;
    result.line_level          = line_level;
    result.tripped             = trip_latch;
    result.link_timeout        = watchdog_latch;
    result.line_levels         = levels;
    result.release_failed_mask = relmask;
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_accept_busy, start && !busy |=> busy, "accepted word did not raise busy")
  `ASSERT_CLK(a_done_idle, done |=> !busy, "block stayed busy after its result")
  `ASSERT_NEVER(a_trip_held, $fell(trip_latch), "trip latch cleared outside reset")
  `ASSERT_NEVER(a_count_range, slot_count > CNT_W'(NUM_SLOTS), "slot count beyond table size")

endmodule
